// ===== hdl/htfd_pkg.sv =====
// Shared types, constants and CRC helper for the humidity/temperature frame decoder.
package htfd_pkg;

    // CRC-8 settings of the sensor response
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Status codes of a result beat
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_BAD = 2'd1,
        STATUS_HUM_BAD  = 2'd2
    } t_status;

    // Completed response handed from the frame assembler to the converter
    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        temp_good;
        logic        hum_good;
    } t_frame;

    // One byte through the CRC, MSB first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/htfd_frame.sv =====
// Byte position tracking, CRC checking and raw word capture for one response.
module htfd_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_start,
    output logic                o_valid,
    input  logic                i_ready,
    output htfd_pkg::t_frame    o_frame
);

    // Byte positions within a response
    localparam logic [2:0] POS_TEMP_MSB = 3'd0;
    localparam logic [2:0] POS_TEMP_LSB = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_MSB  = 3'd3;
    localparam logic [2:0] POS_HUM_LSB  = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    logic [2:0]       r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic [15:0]      r_temp_raw, n_temp_raw;
    logic [15:0]      r_hum_raw, n_hum_raw;
    logic             r_temp_good, n_temp_good;
    logic             r_valid, n_valid;
    htfd_pkg::t_frame r_frame, n_frame;

    logic       accept;
    logic [2:0] pos;
    logic [7:0] crc_base;
    logic [7:0] crc_fed;

    // Take a byte whenever the frame slot is free or draining
    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Start mark or out-of-range position restarts the response
    always_comb begin
        if (i_frame_start || r_pos > POS_HUM_CRC) begin
            pos      = POS_TEMP_MSB;
            crc_base = htfd_pkg::CRC_INIT;
        end else begin
            pos      = r_pos;
            crc_base = r_crc;
        end
    end

    assign crc_fed = htfd_pkg::crc_feed(crc_base, i_rx_byte);

    // Per-byte update
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_temp_raw  = r_temp_raw;
        n_hum_raw   = r_hum_raw;
        n_temp_good = r_temp_good;
        n_valid     = r_valid && !i_ready;
        n_frame     = r_frame;
        if (accept) begin
            n_pos = pos + 3'd1;
            unique case (pos)
                POS_TEMP_MSB: begin
                    n_temp_raw[15:8] = i_rx_byte;
                    n_crc            = crc_fed;
                end
                POS_TEMP_LSB: begin
                    n_temp_raw[7:0] = i_rx_byte;
                    n_crc           = crc_fed;
                end
                POS_TEMP_CRC: begin
                    n_temp_good = (crc_base == i_rx_byte);
                    n_crc       = htfd_pkg::CRC_INIT;
                end
                POS_HUM_MSB: begin
                    n_hum_raw[15:8] = i_rx_byte;
                    n_crc           = crc_fed;
                end
                POS_HUM_LSB: begin
                    n_hum_raw[7:0] = i_rx_byte;
                    n_crc          = crc_fed;
                end
                POS_HUM_CRC: begin
                    n_pos              = POS_TEMP_MSB;
                    n_crc              = htfd_pkg::CRC_INIT;
                    n_valid            = 1'b1;
                    n_frame.temp_raw   = r_temp_raw;
                    n_frame.hum_raw    = r_hum_raw;
                    n_frame.temp_good  = r_temp_good;
                    n_frame.hum_good   = (crc_base == i_rx_byte);
                end
                default: begin
                    n_pos = POS_TEMP_MSB;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_TEMP_MSB;
            r_crc       <= htfd_pkg::CRC_INIT;
            r_temp_good <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_good <= n_temp_good;
            r_valid     <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_temp_raw <= n_temp_raw;
        r_hum_raw  <= n_hum_raw;
        r_frame    <= n_frame;
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule

// ===== hdl/htfd_convert.sv =====
// Raw word scaling, rounding, clamping and the result register.
module htfd_convert (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  htfd_pkg::t_frame   i_frame,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_reading_valid,
    output logic signed [11:0] o_temperature_tenths,
    output logic [6:0]         o_rel_humidity,
    output logic [1:0]         o_status
);

    localparam logic [10:0] TEMP_SCALE = 11'd1750;
    localparam logic [6:0]  HUM_SCALE  = 7'd125;
    localparam logic [15:0] HALF_DEN   = 16'd32767;
    localparam logic [16:0] DEN        = 17'd65535;
    localparam logic signed [11:0] TEMP_OFFSET = 12'sd450;
    localparam logic [6:0]  HUM_OFFSET = 7'd6;
    localparam logic [6:0]  HUM_MAX    = 7'd100;

    logic               r_valid;
    logic               r_reading_valid;
    logic signed [11:0] r_temp;
    logic [6:0]         r_hum;
    htfd_pkg::t_status  r_status;

    logic               accept;
    logic [26:0]        t_num;
    logic [16:0]        t_rem;
    logic [10:0]        t_quo;
    logic signed [11:0] t_val;
    logic [22:0]        h_num;
    logic [16:0]        h_rem;
    logic [6:0]         h_quo;
    logic [6:0]         h_val;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Temperature: round(1750*raw/65535) - 450, divide by 65535 via split and correct
    always_comb begin
        t_num = 27'(TEMP_SCALE * i_frame.temp_raw) + 27'(HALF_DEN);
        t_rem = {1'b0, t_num[15:0]} + 17'(t_num[26:16]);
        t_quo = t_num[26:16] + 11'(t_rem >= DEN);
        t_val = $signed({1'b0, t_quo}) - TEMP_OFFSET;
    end

    // Humidity: round(125*raw/65535) - 6, clamped to 0..100
    always_comb begin
        h_num = 23'(HUM_SCALE * i_frame.hum_raw) + 23'(HALF_DEN);
        h_rem = {1'b0, h_num[15:0]} + 17'(h_num[22:16]);
        h_quo = h_num[22:16] + 7'(h_rem >= DEN);
        if (h_quo < HUM_OFFSET) begin
            h_val = '0;
        end else if (h_quo - HUM_OFFSET > HUM_MAX) begin
            h_val = HUM_MAX;
        end else begin
            h_val = h_quo - HUM_OFFSET;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload; first failing word wins
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!i_frame.temp_good) begin
                r_reading_valid <= 1'b0;
                r_temp          <= '0;
                r_hum           <= '0;
                r_status        <= htfd_pkg::STATUS_TEMP_BAD;
            end else if (!i_frame.hum_good) begin
                r_reading_valid <= 1'b0;
                r_temp          <= '0;
                r_hum           <= '0;
                r_status        <= htfd_pkg::STATUS_HUM_BAD;
            end else begin
                r_reading_valid <= 1'b1;
                r_temp          <= t_val;
                r_hum           <= h_val;
                r_status        <= htfd_pkg::STATUS_OK;
            end
        end
    end

    assign o_valid              = r_valid;
    assign o_reading_valid      = r_reading_valid;
    assign o_temperature_tenths = r_temp;
    assign o_rel_humidity       = r_hum;
    assign o_status             = r_status;

endmodule

// ===== hdl/humidity_temp_frame_decoder.sv =====
// Top level: sensor response byte stream in, decoded reading beat out.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------------
//   in      | input     | i_in_valid/o_in_ready  | i_rx_byte, i_frame_start
//   out     | output    | o_out_valid/i_out_ready| o_reading_valid, o_temperature_tenths,
//           |           |                        | o_rel_humidity, o_status
//
// One byte beat is taken every cycle while the frame register is free or draining; the
// sixth byte of a response yields one result beat via the frame register, then the result register.
// Reset clears byte position, CRC, the temperature CRC flag and both valid flags; raw words are not reset.
// A stalled result holds only the stages behind it; the frame register lets a
// new response keep streaming in while the previous result waits.
module humidity_temp_frame_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_reading_valid,
    output logic signed [11:0] o_temperature_tenths,
    output logic [6:0]         o_rel_humidity,
    output logic [1:0]         o_status
);

    logic             frame_valid;
    logic             frame_ready;
    htfd_pkg::t_frame frame;

    // Byte assembly and CRC checks
    htfd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_valid       (frame_valid),
        .i_ready       (frame_ready),
        .o_frame       (frame)
    );

    // Scaling and result register
    htfd_convert u_convert (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (frame_valid),
        .o_ready              (frame_ready),
        .i_frame              (frame),
        .o_valid              (o_out_valid),
        .i_ready              (i_out_ready),
        .o_reading_valid      (o_reading_valid),
        .o_temperature_tenths (o_temperature_tenths),
        .o_rel_humidity       (o_rel_humidity),
        .o_status             (o_status)
    );

    // An invalid reading always carries a failing status and zero values
    a_invalid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reading_valid |->
            (o_status == htfd_pkg::STATUS_TEMP_BAD || o_status == htfd_pkg::STATUS_HUM_BAD)
            && o_temperature_tenths == 12'sd0 && o_rel_humidity == 7'd0)
        else $error("invalid reading with bad status or nonzero values");

    // A valid reading is in range and reports ok
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reading_valid |->
            o_status == htfd_pkg::STATUS_OK && o_rel_humidity <= 7'd100
            && o_temperature_tenths >= -12'sd450 && o_temperature_tenths <= 12'sd1300)
        else $error("valid reading out of range");

    // No result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat after reset");

    // A byte beat never produces a result in the following cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !frame_valid && !o_out_valid |=> !o_out_valid)
        else $error("result beat without a completed frame");

endmodule

// ===== bench/htfd_reading_checker.sv =====
// Watches both channels of the frame decoder, predicts every reading and compares.
module htfd_reading_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_reading_valid,
    input  logic signed [11:0] i_temperature_tenths,
    input  logic [6:0]         i_rel_humidity,
    input  logic [1:0]         i_status,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    // Conversion constants
    localparam longint FULL_SCALE  = 65535;
    localparam longint TEMP_OFFSET = -450;
    localparam longint TEMP_SPAN   = 1750;
    localparam longint HUM_OFFSET  = -6;
    localparam longint HUM_SPAN    = 125;
    localparam longint HUM_CEIL    = 100;
    localparam int     REPORT_CAP  = 40;

    typedef struct {
        logic               valid;
        logic signed [11:0] temp;
        logic [6:0]         hum;
        htfd_pkg::t_status  status;
    } t_reading;

    t_reading    pending_readings[$];
    t_reading    head;

    // Shadow of the decoder state
    logic [2:0]  byte_pos;
    logic [7:0]  crc_acc;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_crc_ok;

    // CRC-8, one data bit at a time, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            if (r[7] ^ b[i]) begin
                r = {r[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Divide by full scale, nearest, halves away from zero
    function automatic longint round_scaled(input longint num);
        if (num >= 0) begin
            return (num + FULL_SCALE / 2) / FULL_SCALE;
        end
        return -((-num + FULL_SCALE / 2) / FULL_SCALE);
    endfunction

    // Advance the shadow state by one byte; queue a reading on the sixth
    task automatic decode_byte(input logic [7:0] b, input logic mark);
        logic [2:0] p;
        logic       hum_crc_ok;
        longint     tv;
        longint     hv;
        t_reading   r;
        p = byte_pos;
        if (mark || p > 3'd5) begin
            p       = 3'd0;
            crc_acc = htfd_pkg::CRC_INIT;
        end
        case (p)
            3'd0: begin
                temp_word[15:8] = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            3'd1: begin
                temp_word[7:0] = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            3'd2: begin
                temp_crc_ok = (crc_acc == b);
                crc_acc = htfd_pkg::CRC_INIT;
            end
            3'd3: begin
                hum_word[15:8] = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            3'd4: begin
                hum_word[7:0] = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            default: ;
        endcase
        if (p != 3'd5) begin
            byte_pos = p + 3'd1;
        end else begin
            hum_crc_ok = (crc_acc == b);
            crc_acc    = htfd_pkg::CRC_INIT;
            byte_pos   = 3'd0;
            if (!temp_crc_ok || !hum_crc_ok) begin
                r.valid  = 1'b0;
                r.temp   = '0;
                r.hum    = '0;
                r.status = temp_crc_ok ? htfd_pkg::STATUS_HUM_BAD : htfd_pkg::STATUS_TEMP_BAD;
            end else begin
                tv = round_scaled(TEMP_OFFSET * FULL_SCALE + TEMP_SPAN * longint'(temp_word));
                hv = round_scaled(HUM_OFFSET * FULL_SCALE + HUM_SPAN * longint'(hum_word));
                if (hv < 0) hv = 0;
                if (hv > HUM_CEIL) hv = HUM_CEIL;
                r.valid  = 1'b1;
                r.temp   = tv[11:0];
                r.hum    = hv[6:0];
                r.status = htfd_pkg::STATUS_OK;
            end
            pending_readings.push_back(r);
        end
    endtask

    task automatic note_mismatch(input string field, input logic signed [31:0] exp_v,
                                 input logic signed [31:0] act_v);
        o_fail_count++;
        if (o_fail_count <= REPORT_CAP) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Both handshakes are sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_pos    = 3'd0;
            crc_acc     = htfd_pkg::CRC_INIT;
            temp_word   = '0;
            hum_word    = '0;
            temp_crc_ok = 1'b0;
            pending_readings.delete();
        end else begin
            // result beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (pending_readings.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_CAP) begin
                        $display({"%0t: reading beat with none predicted ",
                                  "(valid %0b temp %0d hum %0d status %0d)"},
                                 $time, i_reading_valid, i_temperature_tenths,
                                 i_rel_humidity, i_status);
                    end
                end else begin
                    head = pending_readings.pop_front();
                    o_checked++;
                    if (i_reading_valid !== head.valid)
                        note_mismatch("reading_valid", head.valid, i_reading_valid);
                    if (i_temperature_tenths !== head.temp)
                        note_mismatch("temperature_tenths", head.temp, i_temperature_tenths);
                    if (i_rel_humidity !== head.hum)
                        note_mismatch("rel_humidity", head.hum, i_rel_humidity);
                    if (i_status !== head.status)
                        note_mismatch("status", head.status, i_status);
                end
            end
            // byte beat into the predictor
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_rx_byte, i_frame_start);
            end
        end
        o_pending = pending_readings.size();
    end

endmodule

// ===== bench/humidity_temp_frame_decoder_tb.sv =====
// Stimulus, flow control and verdict for the humidity/temperature frame decoder.
module humidity_temp_frame_decoder_tb;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_rx_byte;
    logic               i_frame_start;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_reading_valid;
    logic signed [11:0] o_temperature_tenths;
    logic [6:0]         o_rel_humidity;
    logic [1:0]         o_status;

    int fail_count;
    int pending;
    int checked;
    int bytes_sent;
    int frames_sent;
    int hold_left;
    bit idling_on;
    bit hold_req;

    humidity_temp_frame_decoder dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_rx_byte            (i_rx_byte),
        .i_frame_start        (i_frame_start),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_reading_valid      (o_reading_valid),
        .o_temperature_tenths (o_temperature_tenths),
        .o_rel_humidity       (o_rel_humidity),
        .o_status             (o_status)
    );

    htfd_reading_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_ready           (o_in_ready),
        .i_rx_byte            (i_rx_byte),
        .i_frame_start        (i_frame_start),
        .i_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .i_reading_valid      (o_reading_valid),
        .i_temperature_tenths (o_temperature_tenths),
        .i_rel_humidity       (o_rel_humidity),
        .i_status             (o_status),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_checked            (checked)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog
    initial begin
        #2_000_000;
        $display("%0t: timeout, run did not complete", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        i_out_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(idling_on && $urandom_range(99, 0) < 9);
            end
        end
    end

    // One byte beat; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic mark);
        if (idling_on && $urandom_range(99, 0) < 9) begin
            i_in_valid <= 1'b0;
            i_rx_byte  <= 8'($urandom);
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= mark;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Full six-byte response, optionally with a corrupted CRC byte per word
    task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic t_bad, input logic h_bad, input logic mark);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = htfd_pkg::crc_feed(htfd_pkg::crc_feed(htfd_pkg::CRC_INIT, t_raw[15:8]),
                                   t_raw[7:0]);
        h_crc = htfd_pkg::crc_feed(htfd_pkg::crc_feed(htfd_pkg::CRC_INIT, h_raw[15:8]),
                                   h_raw[7:0]);
        if (t_bad) t_crc = t_crc ^ 8'($urandom_range(255, 1));
        if (h_bad) h_crc = h_crc ^ 8'($urandom_range(255, 1));
        send_byte(t_raw[15:8], mark);
        send_byte(t_raw[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(h_raw[15:8], 1'b0);
        send_byte(h_raw[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
        frames_sent++;
    endtask

    // Raw word, with the ends of the range showing up often
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(7, 0))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(3000, 0));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed responses, the rest truncated junk with random start marks
    task automatic random_traffic(input int n_bytes);
        int  stop_at;
        int  sel;
        int  junk_len;
        bit  need_mark;
        stop_at   = bytes_sent + n_bytes;
        need_mark = 1'b1;
        while (bytes_sent < stop_at) begin
            sel = $urandom_range(99, 0);
            if (sel < 85) begin
                sel = $urandom_range(9, 0);
                send_frame(pick_raw(), pick_raw(), sel == 7 || sel == 9, sel == 8 || sel == 9,
                           need_mark || $urandom_range(3, 0) != 0);
                need_mark = 1'b0;
            end else begin
                junk_len = $urandom_range(5, 1);
                repeat (junk_len) send_byte(8'($urandom), $urandom_range(3, 0) == 0);
                need_mark = 1'b1;
            end
        end
    endtask

    // Stop offering bytes until every predicted reading is out
    task automatic wait_readings_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = 8'h00;
        i_frame_start = 1'b0;
        idling_on     = 1'b1;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        frames_sent   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: range extremes with clamping, missing start mark,
        // resync after a partial response, both CRCs bad, humidity CRC bad
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_frame(16'h1234, 16'h8000, 1'b1, 1'b1, 1'b1);
        send_frame(16'h6666, 16'h7FFF, 1'b0, 1'b1, 1'b1);

        random_traffic(500);
        wait_readings_drained();

        // stretch with no idling on either side
        idling_on = 1'b0;
        random_traffic(400);
        idling_on = 1'b1;

        // receiver holds off while bytes keep coming
        hold_req = 1'b1;
        random_traffic(60);
        random_traffic(500);

        wait_readings_drained();
        if (pending != 0) begin
            $display("%0t: %0d predicted readings never arrived", $time, pending);
        end

        $display("Run covered %0d byte beats in %0d full responses, %0d readings compared,",
                 bytes_sent, frames_sent, checked);
        $display("with CRC failures, resyncs, junk bytes, random stalls and a long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
